// File: src/bsdec_pkg.sv
// Package for the base32 stream decoder: word types, the job format
// passed from the front part to the back part, and the alphabet lookup.
// No dependencies.
package bsdec_pkg;

    // Fixed sizes of the decoding scheme.
    localparam int SYM_WIDTH       = 5;
    localparam int SYMS_PER_GROUP  = 8;
    localparam int BYTES_PER_GROUP = 5;
    localparam int GROUP_WIDTH     = SYM_WIDTH * SYMS_PER_GROUP;   // 40
    localparam int HOLD_WIDTH      = GROUP_WIDTH - SYM_WIDTH;      // 35
    localparam int COUNT_WIDTH     = 3;
    localparam int NBYTE_WIDTH     = 3;
    localparam int TOTAL_OUT_WIDTH = 16;

    // Default width of the saturating byte total.
    localparam int TOTAL_WIDTH_DEFAULT = 16;

    // Depth of the job queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Characters of the alphabet.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_DIGIT_2 = 8'h32;
    localparam logic [7:0] CHAR_DIGIT_7 = 8'h37;
    localparam logic [SYM_WIDTH-1:0] DIGIT_BASE = 5'd26;

    // Input word.
    typedef struct packed {
        logic [7:0] in_char;
        logic       char_present;
        logic       end_of_source;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic [7:0]                 out_byte;
        logic                       byte_valid;
        logic                       run_last;
        logic                       message_end;
        logic [TOTAL_OUT_WIDTH-1:0] total_bytes;
    } t_out_word;

    // One job: up to five bytes, most significant first, and an end mark.
    // A job with no bytes is only queued at end of source.
    typedef struct packed {
        logic [GROUP_WIDTH-1:0] data;
        logic [NBYTE_WIDTH-1:0] nbytes;
        logic                   eos;
    } t_job;

    // Result of the alphabet lookup.
    typedef struct packed {
        logic                 ok;
        logic [SYM_WIDTH-1:0] val;
    } t_sym;

    // Map a character through the standard alphabet.
    function automatic t_sym sym_decode(input logic [7:0] c);
        t_sym s;
        s.ok  = 1'b0;
        s.val = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            s.ok  = 1'b1;
            s.val = SYM_WIDTH'(c - CHAR_UPPER_A);
        end else if (c >= CHAR_DIGIT_2 && c <= CHAR_DIGIT_7) begin
            s.ok  = 1'b1;
            s.val = SYM_WIDTH'(c - CHAR_DIGIT_2) + DIGIT_BASE;
        end
        return s;
    endfunction

    // Left-align a partial group of cnt symbols in a zero-filled group.
    function automatic logic [GROUP_WIDTH-1:0] flush_align(
        input logic [HOLD_WIDTH-1:0]  g,
        input logic [COUNT_WIDTH-1:0] cnt
    );
        logic [GROUP_WIDTH-1:0] r;
        case (cnt)
            3'd1:    r = {g[4:0],  35'b0};
            3'd2:    r = {g[9:0],  30'b0};
            3'd3:    r = {g[14:0], 25'b0};
            3'd4:    r = {g[19:0], 20'b0};
            3'd5:    r = {g[24:0], 15'b0};
            3'd6:    r = {g[29:0], 10'b0};
            3'd7:    r = {g[34:0], 5'b0};
            default: r = '0;
        endcase
        return r;
    endfunction

    // Whole bytes held in a partial group: floor(cnt * 5 / 8).
    function automatic logic [NBYTE_WIDTH-1:0] flush_bytes(
        input logic [COUNT_WIDTH-1:0] cnt
    );
        logic [NBYTE_WIDTH-1:0] n;
        case (cnt)
            3'd2, 3'd3: n = 3'd1;
            3'd4:       n = 3'd2;
            3'd5, 3'd6: n = 3'd3;
            3'd7:       n = 3'd4;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// File: src/bsdec_front.sv
// Front part of the base32 stream decoder: accepts characters, collects
// symbols, tracks the stop condition and queues byte jobs.
// Depends on bsdec_pkg.
module bsdec_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bsdec_pkg::t_in_word i_in_word,
    output logic              o_push,
    output bsdec_pkg::t_job   o_job,
    input  logic              i_full
);
    import bsdec_pkg::*;

    logic [HOLD_WIDTH-1:0]  r_group, n_group;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_stopped, n_stopped;
    logic                   accept;
    logic                   consume;
    logic                   take;
    logic                   group_done;
    logic                   push;
    logic [GROUP_WIDTH-1:0] wide_group;
    t_sym                   sym;
    t_job                   job;

    // A word is taken whenever the queue has room.
    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    // Classify the character and work out the next collector state.
    always_comb begin
        sym        = sym_decode(i_in_word.in_char);
        consume    = i_in_word.char_present && !r_stopped;
        take       = consume && sym.ok;
        wide_group = {r_group, sym.val};
        group_done = take && (r_count == COUNT_WIDTH'(SYMS_PER_GROUP - 1));
        n_group    = r_group;
        n_count    = r_count;
        n_stopped  = r_stopped;
        push       = 1'b0;
        job        = '0;

        if (take) begin
            if (group_done) begin
                push       = 1'b1;
                job.data   = wide_group;
                job.nbytes = NBYTE_WIDTH'(BYTES_PER_GROUP);
                n_group    = '0;
                n_count    = '0;
            end else begin
                n_group = wide_group[HOLD_WIDTH-1:0];
                n_count = r_count + 1'b1;
            end
        end else if (consume) begin
            n_stopped = 1'b1;
        end

        // End of source: flush the remainder, or mark the full group as last.
        if (i_in_word.end_of_source) begin
            push    = 1'b1;
            job.eos = 1'b1;
            if (!group_done) begin
                job.data   = flush_align(n_group, n_count);
                job.nbytes = flush_bytes(n_count);
            end
            n_group   = '0;
            n_count   = '0;
            n_stopped = 1'b0;
        end
    end

    assign o_push = accept && push;
    assign o_job  = job;

    // Collector registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group   <= '0;
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else if (accept) begin
            r_group   <= n_group;
            r_count   <= n_count;
            r_stopped <= n_stopped;
        end
    end

endmodule

// File: src/bsdec_queue.sv
// Short job queue between the front and back parts of the decoder.
// Depends on bsdec_pkg.
module bsdec_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bsdec_pkg::t_job i_job,
    output logic            o_full,
    output logic            o_valid,
    output bsdec_pkg::t_job o_job,
    input  logic            i_pop
);
    import bsdec_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);

    t_job           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: src/bsdec_back.sv
// Back part of the base32 stream decoder: unpacks queued jobs into one output
// word per byte, or a bare word if none, and keeps the saturating byte total.
// Depends on bsdec_pkg.
module bsdec_back #(
    parameter int TOTAL_WIDTH = bsdec_pkg::TOTAL_WIDTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  bsdec_pkg::t_job     i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bsdec_pkg::t_out_word o_out_word
);
    import bsdec_pkg::*;

    logic                   r_busy;
    logic [GROUP_WIDTH-1:0] r_data;
    logic [NBYTE_WIDTH-1:0] r_left;
    logic                   r_eos;
    logic [TOTAL_WIDTH-1:0] r_total, n_total;
    logic                   r_out_valid;
    t_out_word              r_out, n_out;
    logic                   adv;
    logic                   bare;
    logic                   last;
    logic                   fin;

    // One byte leaves per cycle while the output register can take it.
    assign adv  = r_busy && (!r_out_valid || !i_out_stall);
    assign bare = (r_left == '0);
    assign last = (r_left <= NBYTE_WIDTH'(1));
    assign fin  = adv && last;
    assign o_pop = i_job_valid && (!r_busy || fin);

    // Build the next output word and the updated total.
    always_comb begin
        n_total = r_total;
        if (!bare && (r_total != {TOTAL_WIDTH{1'b1}})) begin
            n_total = r_total + 1'b1;
        end
        n_out.out_byte    = bare ? 8'd0 : r_data[GROUP_WIDTH-1 -: 8];
        n_out.byte_valid  = !bare;
        n_out.run_last    = last;
        n_out.message_end = r_eos && last;
        n_out.total_bytes = TOTAL_OUT_WIDTH'(n_total);
    end

    // Current job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
            r_eos  <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_left <= i_job.nbytes;
            r_eos  <= i_job.eos;
        end else if (fin) begin
            r_busy <= 1'b0;
        end else if (adv) begin
            r_left <= r_left - 1'b1;
        end
    end

    // Byte shifter of the current job.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_job.data;
        end else if (adv) begin
            r_data <= r_data << 8;
        end
    end

    // Byte total, cleared after the end of each message.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (adv) begin
            r_total <= n_out.message_end ? '0 : n_total;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// File: src/base32_stream_decoder.sv
// Top level of the base32 stream decoder: front part, job queue, back part.
// Depends on bsdec_pkg, bsdec_front, bsdec_queue and bsdec_back.
//
//   Channel   Valid        Stall        Word
//   input     i_in_valid   o_in_stall   i_in_word  (character, present, end)
//   output    o_out_valid  i_out_stall  o_out_word (byte, flags, total)
//
// The front part takes one character word per cycle while the four-entry
// job queue has room. Eight symbols or an end of source make one job.
// The back part sends one output word per cycle, up to five per job, while
// the output is not stalled, and pops the next job with the last word of the
// current one. Output words leave through the back part's output register.
// Reset is synchronous and active low; it clears all control state.
module base32_stream_decoder #(
    parameter int TOTAL_WIDTH = bsdec_pkg::TOTAL_WIDTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bsdec_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bsdec_pkg::t_out_word o_out_word
);
    import bsdec_pkg::*;

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_job front_job;
    t_job back_job;

    // Character intake and symbol collection.
    bsdec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_push     (q_push),
        .o_job      (front_job),
        .i_full     (q_full)
    );

    // Job queue.
    bsdec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (back_job),
        .i_pop   (q_pop)
    );

    // Byte output.
    bsdec_back #(
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (back_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// File: src/bsdec_checker.sv
// Port-level checks for the base32 stream decoder, bound to its top level.
// Depends on bsdec_pkg and base32_stream_decoder.
module bsdec_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input bsdec_pkg::t_in_word  i_in_word,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input bsdec_pkg::t_out_word o_out_word
);
    import bsdec_pkg::*;

    // A stalled output word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // The end of a message always closes the run of its input word.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.message_end |-> o_out_word.run_last)
        else $error("message end without run end");

    // A word without a byte is only the bare end of a message, with zero data.
    a_bare_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.byte_valid |->
            o_out_word.message_end && (o_out_word.out_byte == 8'd0))
        else $error("word without byte is not a bare message end");

endmodule

bind base32_stream_decoder bsdec_checker u_bsdec_checker (.*);

// File: test/base32_stream_decoder_checker.sv
// Checker for the base32 stream decoder: watches both channels, predicts the output words
// from the accepted input words and compares them field by field.
// Depends on bsdec_pkg for the word types and alphabet characters.
module base32_stream_decoder_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  bsdec_pkg::t_in_word  i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  bsdec_pkg::t_out_word i_out_word,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import bsdec_pkg::*;

    // Decoder state as the prediction sees it.
    logic [HOLD_WIDTH-1:0]      held_syms;
    logic [COUNT_WIDTH-1:0]     held_count;
    bit                         stop_seen;
    logic [TOTAL_OUT_WIDTH-1:0] byte_count;

    // Output words still owed by the block, oldest first.
    t_out_word due_words[$];

    int fails   = 0;
    int checked = 0;

    // Return to the state of a fresh message.
    task automatic clear_state();
        held_syms  = '0;
        held_count = '0;
        stop_seen  = 1'b0;
        byte_count = '0;
    endtask

    // One decoded byte; the running total saturates at its maximum.
    function automatic t_out_word byte_word(input logic [7:0] b);
        t_out_word ow;
        if (byte_count != '1) begin
            byte_count++;
        end
        ow.out_byte    = b;
        ow.byte_valid  = 1'b1;
        ow.run_last    = 1'b0;
        ow.message_end = 1'b0;
        ow.total_bytes = byte_count;
        return ow;
    endfunction

    // Work out the output words that one accepted input word causes.
    task automatic decode_word(input t_in_word w);
        t_out_word             batch[BYTES_PER_GROUP];
        logic [GROUP_WIDTH-1:0] grp;
        logic [SYM_WIDTH-1:0]  sym;
        bit                    is_sym;
        int                    n;
        int                    nb;
        int                    k;
        n = 0;

        // Consume the character unless decoding has already stopped.
        if (w.char_present && !stop_seen) begin
            is_sym = 1'b1;
            sym    = '0;
            if (w.in_char >= CHAR_UPPER_A && w.in_char <= CHAR_UPPER_Z) begin
                sym = SYM_WIDTH'(w.in_char - CHAR_UPPER_A);
            end else if (w.in_char >= CHAR_DIGIT_2 && w.in_char <= CHAR_DIGIT_7) begin
                sym = SYM_WIDTH'(w.in_char - CHAR_DIGIT_2 + 8'd26);
            end else begin
                is_sym = 1'b0;
            end

            if (!is_sym) begin
                stop_seen = 1'b1;
            end else if (held_count == 3'd7) begin
                // Eighth symbol: the whole group leaves as five bytes.
                grp = {held_syms, sym};
                for (k = 0; k < BYTES_PER_GROUP; k++) begin
                    batch[n] = byte_word(grp[GROUP_WIDTH - 1 - 8 * k -: 8]);
                    n++;
                end
                held_syms  = '0;
                held_count = '0;
            end else begin
                held_syms  = {held_syms[HOLD_WIDTH-SYM_WIDTH-1:0], sym};
                held_count = held_count + 3'd1;
            end
        end

        // End of source: flush whole bytes of the partial group, then mark the end.
        if (w.end_of_source) begin
            grp = {held_syms, {SYM_WIDTH{1'b0}}} << (SYM_WIDTH * (7 - int'(held_count)));
            nb  = (int'(held_count) * SYM_WIDTH) / 8;
            for (k = 0; k < nb; k++) begin
                batch[n] = byte_word(grp[GROUP_WIDTH - 1 - 8 * k -: 8]);
                n++;
            end
            if (n == 0) begin
                batch[0].out_byte    = 8'h00;
                batch[0].byte_valid  = 1'b0;
                batch[0].run_last    = 1'b0;
                batch[0].message_end = 1'b0;
                batch[0].total_bytes = byte_count;
                n = 1;
            end
            batch[n-1].message_end = 1'b1;
            clear_state();
        end

        if (n > 0) begin
            batch[n-1].run_last = 1'b1;
        end
        for (k = 0; k < n; k++) begin
            due_words.push_back(batch[k]);
        end
    endtask

    // Compare one output word with the oldest owed word.
    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (due_words.size() == 0) begin
            $error("output word %h arrived with no word expected", got);
            fails++;
            return;
        end
        want = due_words.pop_front();
        checked++;
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
            fails++;
        end
        if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %b, actual %b", want.byte_valid, got.byte_valid);
            fails++;
        end
        if (got.run_last !== want.run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
            fails++;
        end
        if (got.message_end !== want.message_end) begin
            $error("message_end: expected %b, actual %b", want.message_end, got.message_end);
            fails++;
        end
        if (got.total_bytes !== want.total_bytes) begin
            $error("total_bytes: expected %0d, actual %0d", want.total_bytes, got.total_bytes);
            fails++;
        end
    endtask

    // Sample both channels at the clock edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            due_words.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                decode_word(i_in_word);
            end
            if (i_out_valid && !i_out_stall) begin
                check_word(i_out_word);
            end
        end
        o_pending    <= due_words.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// File: test/base32_stream_decoder_tb.sv
// Testbench top for the base32 stream decoder: clock, reset, character stimulus,
// output stall pattern and the final verdict.
// Depends on bsdec_pkg, base32_stream_decoder and base32_stream_decoder_checker.
module base32_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsdec_pkg::*;

    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         TAIL_CYCLES  = 16;
    localparam int         RANDOM_ITEMS = 420;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3d;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;

    int fail_count;
    int pending;
    int checked;

    int words_sent    = 0;
    int messages_sent = 0;
    int cycle_count   = 0;
    bit gaps_on       = 1'b0;
    bit stall_on      = 1'b0;
    bit hold_off_req  = 1'b0;

    base32_stream_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    base32_stream_decoder_checker decode_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Idle length: mostly none, often short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Any character of the base32 alphabet.
    function automatic logic [7:0] rand_symbol();
        logic [7:0] v;
        v = 8'($urandom_range(0, 31));
        return (v < 8'd26) ? CHAR_UPPER_A + v : CHAR_DIGIT_2 + v - 8'd26;
    endfunction

    function automatic t_in_word make_word(input logic [7:0] c, input logic p, input logic e);
        t_in_word w;
        w.in_char       = c;
        w.char_present  = p;
        w.end_of_source = e;
        return w;
    endfunction

    // Offer one word, wait until it is taken, then maybe leave a gap.
    task automatic send_word(input t_in_word w);
        int n;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        words_sent++;
        if (gaps_on) begin
            n = idle_len();
            if (n > 0) begin
                in_valid <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    endtask

    task automatic send_text(input string s, input bit eos_last);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_word(make_word(s[i], 1'b1, eos_last && (i == s.len() - 1)));
        end
        messages_sent++;
    endtask

    // One source: random symbols ended on the last character, by padding or by an
    // empty end marker; some carry absent characters or a stray stop character.
    task automatic send_message(input bit long_one);
        int       len;
        int       k;
        int       style;
        int       stop_at;
        int       pads;
        t_in_word w;
        if (long_one) begin
            len = 40;
        end else if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(13, 40);
        end else begin
            len = $urandom_range(0, 12);
        end
        style = $urandom_range(0, 2);
        if (len == 0 && style == 0) begin
            style = 2;
        end
        stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : -1;

        for (k = 0; k < len; k++) begin
            w.char_present = ($urandom_range(0, 11) != 0);
            w.in_char      = w.char_present ? rand_symbol() : 8'($urandom_range(0, 255));
            if (k == stop_at) begin
                w.char_present = 1'b1;
                w.in_char      = $urandom_range(0, 1) ? CHAR_EQUALS : 8'($urandom_range(0, 255));
            end
            w.end_of_source = (style == 0) && (k == len - 1);
            send_word(w);
        end

        if (style == 1) begin
            pads = $urandom_range(1, 6);
            for (k = 1; k <= pads; k++) begin
                send_word(make_word(CHAR_EQUALS, 1'b1, k == pads));
            end
        end else if (style == 2) begin
            send_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        end
        messages_sent++;
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int n;
        out_stall <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else if (stall_on) begin
                n = idle_len();
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // Input side and verdict.
    initial begin : stimulus
        int         msg;
        int         base;
        logic [1:0] mode;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a known string ended by padding, an empty source, the top symbol,
        // a stop byte at the top of the range with ignored characters after it, 0x00
        // among them, and a lowercase letter as the only character.
        send_text("MZXW6YTBOI", 1'b0);
        send_word(make_word(CHAR_EQUALS, 1'b1, 1'b1));
        send_word(make_word(8'h00, 1'b0, 1'b1));
        messages_sent++;
        send_text("77777777", 1'b1);
        send_word(make_word(CHAR_UPPER_A, 1'b1, 1'b0));
        send_word(make_word(8'hff, 1'b1, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b0));
        send_word(make_word(CHAR_DIGIT_7, 1'b1, 1'b0));
        send_word(make_word(8'h00, 1'b1, 1'b1));
        messages_sent++;
        send_text("a", 1'b1);

        // Random messages, changing the idling pattern every few messages.
        base = words_sent;
        for (msg = 0; words_sent - base < RANDOM_ITEMS; msg++) begin
            if (msg % 6 == 0) begin
                mode     = 2'($urandom_range(0, 3));
                gaps_on  = mode[0];
                stall_on = mode[1];
            end
            if (msg == 8) begin
                hold_off_req = 1'b1;
            end
            send_message(msg == 8);
        end

        // Drain, then allow for the block's latency.
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d input words in %0d messages, with padding, stop bytes,",
                 words_sent, messages_sent);
        $display("absent characters and one long output hold-off; compared %0d output words.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
